// ----- design/tpd_pkg.sv -----
// Package for the TRIAC phase-angle dimmer sequencer.
// Holds channel count, widths, codes, state enums and payload structs.
// Depends on nothing; every other file refers to it by scoped names.
package tpd_pkg;

    // Number of dimmer channels handled by the sequencer.
    localparam int CHANNELS = 3;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);
    // Gate vector padded so that the three reported gates always exist.
    localparam int GATE_PAD = (CHANNELS > 3) ? CHANNELS : 3;

    // Percent scale and the fixed divisor factor of the compare count.
    localparam logic [6:0] FULL_PERCENT = 7'd100;
    localparam int COMPARE_SCALE = 10000;

    // Divider widths: numerator is a 7-bit difference times a 32-bit clock,
    // denominator is (prescaler + 1) * 10000, which stays below 2^30.
    localparam int NUM_W = 39;
    localparam int DEN_W = 30;
    localparam int CNT_W = $clog2(NUM_W);

    // Command codes of an input item.
    typedef enum logic [1:0] {
        CMD_ZERO_CROSS = 2'd0,
        CMD_COMPARE    = 2'd1,
        CMD_SET_TARGET = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CORE_CLOCK = 2'd0,
        REG_PRESCALER  = 2'd1,
        REG_MAX_PCT    = 2'd2,
        REG_MIN_PCT    = 2'd3
    } reg_idx_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIVIDE,
        ST_EMIT
    } top_state_t;

    // States of the shared divider unit.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // Configuration register set.
    typedef struct packed {
        logic [31:0] core_clock_hz;
        logic [15:0] timer_prescaler;
        logic [6:0]  max_percent;
        logic [6:0]  min_percent;
    } cfg_t;

    // Input item.
    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] channel;
        logic [6:0] target_level;
    } in_t;

    // Result item.
    typedef struct packed {
        logic        gate_zero;
        logic        gate_one;
        logic        gate_two;
        logic        restart_counter;
        logic        compare_valid;
        logic [1:0]  compare_channel;
        logic [15:0] compare_value;
    } out_t;

endpackage

// ----- design/tpd_cfg_regs.sv -----
// Configuration register file of the dimmer sequencer.
// Depends on tpd_pkg for the register indexes and the cfg_t struct.
module tpd_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    output tpd_pkg::cfg_t    cfg
);

    tpd_pkg::cfg_t cfg_reg;
    tpd_pkg::cfg_t cfg_next;

    // Select the register addressed by a write and truncate the data to it.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                tpd_pkg::REG_CORE_CLOCK: cfg_next.core_clock_hz   = cfg_data;
                tpd_pkg::REG_PRESCALER:  cfg_next.timer_prescaler = cfg_data[15:0];
                tpd_pkg::REG_MAX_PCT:    cfg_next.max_percent     = cfg_data[6:0];
                tpd_pkg::REG_MIN_PCT:    cfg_next.min_percent     = cfg_data[6:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // Register set with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.core_clock_hz   <= 32'd48000000;
            cfg_reg.timer_prescaler <= 16'd47;
            cfg_reg.max_percent     <= 7'd100;
            cfg_reg.min_percent     <= 7'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/tpd_divider.sv -----
// Shared compare-count unit: one multiply step, then a restoring divider
// that resolves one quotient bit per cycle, saturated to 16 bits at the end.
// Depends on tpd_pkg for widths, constants, the cfg_t struct and div_state_t.
module tpd_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [6:0]       level,
    input  tpd_pkg::cfg_t    cfg,
    output logic             done,
    output logic [15:0]      quotient
);

    tpd_pkg::div_state_t state_reg, state_next;
    logic [tpd_pkg::CNT_W-1:0] count_reg, count_next;

    logic [6:0]                diff_reg, diff_next;
    logic [tpd_pkg::NUM_W-1:0] numq_reg, numq_next;
    logic [tpd_pkg::DEN_W-1:0] den_reg, den_next;
    logic [tpd_pkg::DEN_W-1:0] rem_reg, rem_next;

    logic [16:0]               psc_plus;
    logic [30:0]               den_full;
    logic [tpd_pkg::DEN_W:0]   trial;
    logic [tpd_pkg::DEN_W:0]   trial_sub;
    logic                      trial_ge;

    // Denominator product and the trial subtraction of the current step.
    always_comb
    begin
        psc_plus  = {1'b0, cfg.timer_prescaler} + 17'd1;
        den_full  = {14'd0, psc_plus} * 31'(tpd_pkg::COMPARE_SCALE);
        trial     = {rem_reg, numq_reg[tpd_pkg::NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        trial_ge  = (trial >= {1'b0, den_reg});
    end

    // Sequencer of the unit and its datapath updates.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        diff_next  = diff_reg;
        numq_next  = numq_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        case (state_reg)
            tpd_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    // Levels above full scale give a zero difference.
                    diff_next  = (level < tpd_pkg::FULL_PERCENT) ?
                                 (tpd_pkg::FULL_PERCENT - level) : 7'd0;
                    state_next = tpd_pkg::DIV_MUL;
                end
            end
            tpd_pkg::DIV_MUL:
            begin
                numq_next  = {32'd0, diff_reg} * {7'd0, cfg.core_clock_hz};
                den_next   = den_full[tpd_pkg::DEN_W-1:0];
                rem_next   = '0;
                count_next = '0;
                state_next = tpd_pkg::DIV_RUN;
            end
            tpd_pkg::DIV_RUN:
            begin
                rem_next  = trial_ge ? trial_sub[tpd_pkg::DEN_W-1:0] :
                                       trial[tpd_pkg::DEN_W-1:0];
                numq_next = {numq_reg[tpd_pkg::NUM_W-2:0], trial_ge};
                count_next = count_reg + 1'b1;
                if (count_reg == tpd_pkg::CNT_W'(tpd_pkg::NUM_W - 1))
                begin
                    state_next = tpd_pkg::DIV_DONE;
                end
            end
            tpd_pkg::DIV_DONE:
            begin
                state_next = tpd_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = tpd_pkg::DIV_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpd_pkg::DIV_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        numq_reg <= numq_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    // The quotient saturates when any bit above the low 16 is set.
    assign done     = (state_reg == tpd_pkg::DIV_DONE);
    assign quotient = (|numq_reg[tpd_pkg::NUM_W-1:16]) ? 16'hFFFF : numq_reg[15:0];

endmodule

// ----- design/triac_phase_dimmer_ramp.sv -----
// Top level of the TRIAC phase-angle dimmer sequencer: channel state,
// command sequencer and output register. Uses tpd_pkg, tpd_cfg_regs and
// tpd_divider.
//
//   Channel   Handshake                Payload
//   in        in_valid / in_ready      in_data  (tpd_pkg::in_t)
//   out       out_valid / out_ready    out_data (tpd_pkg::out_t)
//   cfg       cfg_write_en             cfg_index, cfg_data
//
// An accepted item without a level change passes ST_EXEC and ST_EMIT into the
// output register; a compare item that moves a level also waits in ST_DIVIDE
// for the multiply step and the 39-step restoring divider of the compare count.
// The input is ready again at the edge that loads the result; no new item is
// taken while the previous one is still in the sequencer.
// Reset clears all channel state and loads the register reset values.
// An item is taken while a result still waits; a stalled output holds the
// following item in the sequencer until the output register frees up.
module triac_phase_dimmer_ramp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tpd_pkg::in_t     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tpd_pkg::out_t    out_data,
    input  logic             cfg_write_en,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    tpd_pkg::cfg_t cfg;

    tpd_pkg::top_state_t state_reg, state_next;

    tpd_pkg::in_t  item_reg;
    tpd_pkg::out_t res_reg, res_next;
    tpd_pkg::out_t out_data_reg;
    logic          out_valid_reg, out_valid_next;

    logic [tpd_pkg::CHANNELS-1:0] pend_reg, pend_next;
    logic [tpd_pkg::CHANNELS-1:0] gate_reg, gate_next;
    logic [6:0] level_reg [tpd_pkg::CHANNELS];
    logic [6:0] level_next [tpd_pkg::CHANNELS];
    logic [6:0] tgt_reg [tpd_pkg::CHANNELS];
    logic [6:0] tgt_next [tpd_pkg::CHANNELS];

    logic [3:0]                    ch_ext;
    logic                          ch_ok;
    logic [tpd_pkg::CH_IDX_W-1:0]  ch_idx;
    logic [tpd_pkg::GATE_PAD-1:0]  gate_pad;
    logic                          div_start;
    logic                          div_done;
    logic [15:0]                   div_quotient;

    tpd_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    tpd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .level    (level_next[ch_idx]),
        .cfg      (cfg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Channel decode of the held item.
    always_comb
    begin
        ch_ext = {2'b00, item_reg.channel};
        ch_ok  = (ch_ext < tpd_pkg::CH_LIMIT);
        ch_idx = ch_ext[tpd_pkg::CH_IDX_W-1:0];
    end

    // Sequencer: next state, channel state updates and result staging.
    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        gate_next      = gate_reg;
        level_next     = level_reg;
        tgt_next       = tgt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;
        in_ready       = (state_reg == tpd_pkg::ST_IDLE);
        gate_pad       = '0;
        case (state_reg)
            tpd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tpd_pkg::ST_EXEC;
                end
            end
            tpd_pkg::ST_EXEC:
            begin
                res_next.restart_counter = 1'b0;
                res_next.compare_valid   = 1'b0;
                res_next.compare_channel = 2'd0;
                res_next.compare_value   = 16'd0;
                case (item_reg.cmd)
                    tpd_pkg::CMD_ZERO_CROSS:
                    begin
                        // Taken only when no channel still waits for its fire.
                        if (pend_reg == '0)
                        begin
                            for (int i = 0; i < tpd_pkg::CHANNELS; i++)
                            begin
                                pend_next[i] = 1'b1;
                                if (level_reg[i] < cfg.max_percent)
                                begin
                                    gate_next[i] = 1'b0;
                                end
                            end
                            res_next.restart_counter = 1'b1;
                        end
                    end
                    tpd_pkg::CMD_COMPARE:
                    begin
                        if (ch_ok)
                        begin
                            if (pend_reg[ch_idx])
                            begin
                                pend_next[ch_idx] = 1'b0;
                                if (level_reg[ch_idx] > cfg.min_percent)
                                begin
                                    gate_next[ch_idx] = 1'b1;
                                end
                            end
                            // Ramp one percent toward the target.
                            if (level_reg[ch_idx] != tgt_reg[ch_idx])
                            begin
                                if (level_reg[ch_idx] > tgt_reg[ch_idx])
                                begin
                                    level_next[ch_idx] = level_reg[ch_idx] - 7'd1;
                                end
                                else
                                begin
                                    level_next[ch_idx] = level_reg[ch_idx] + 7'd1;
                                end
                                res_next.compare_valid   = 1'b1;
                                res_next.compare_channel = item_reg.channel;
                                div_start                = 1'b1;
                            end
                        end
                    end
                    tpd_pkg::CMD_SET_TARGET:
                    begin
                        if (ch_ok)
                        begin
                            tgt_next[ch_idx] =
                                (item_reg.target_level > tpd_pkg::FULL_PERCENT) ?
                                tpd_pkg::FULL_PERCENT : item_reg.target_level;
                        end
                    end
                    default:
                    begin
                        res_next.restart_counter = 1'b0;
                    end
                endcase
                gate_pad[tpd_pkg::CHANNELS-1:0] = gate_next;
                res_next.gate_zero = gate_pad[0];
                res_next.gate_one  = gate_pad[1];
                res_next.gate_two  = gate_pad[2];
                state_next = div_start ? tpd_pkg::ST_DIVIDE : tpd_pkg::ST_EMIT;
            end
            tpd_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_next.compare_value = div_quotient;
                    state_next             = tpd_pkg::ST_EMIT;
                end
            end
            tpd_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = tpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
            gate_reg      <= '0;
            for (int i = 0; i < tpd_pkg::CHANNELS; i++)
            begin
                level_reg[i] <= 7'd0;
                tgt_reg[i]   <= 7'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            gate_reg      <= gate_next;
            level_reg     <= level_next;
            tgt_reg       <= tgt_next;
        end
    end

    // Payload registers: held item, staged result and output register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        res_reg <= res_next;
        if ((state_reg == tpd_pkg::ST_EMIT) && (!out_valid_reg || out_ready))
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/tpd_checker.sv -----
// Port-level checker of the dimmer sequencer, bound to the top level.
// Depends on tpd_pkg for the payload structs and the channel count.
module tpd_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             out_valid,
    input  logic             out_ready,
    input  tpd_pkg::out_t    out_data
);

    // A result that is not taken stays offered unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // The sequencer works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while the previous one is at work");

    // A zero cross never also produces a compare update.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.restart_counter && out_data.compare_valid))
        else $error("restart and compare update in one result");

    // Without a compare update the compare fields are zero; with one,
    // the channel is a real channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.compare_valid ?
            ({2'b00, out_data.compare_channel} < tpd_pkg::CH_LIMIT) :
            (out_data.compare_channel == 2'd0 && out_data.compare_value == 16'd0)))
        else $error("compare fields inconsistent with compare_valid");

endmodule

bind triac_phase_dimmer_ramp tpd_checker u_tpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/triac_phase_dimmer_ramp_tb.sv -----
// Self-checking testbench for the TRIAC phase-angle dimmer sequencer.
// A directed table and then random half-cycle sequences are checked against
// a local predictor. Depends on tpd_pkg and the triac_phase_dimmer_ramp RTL.
module triac_phase_dimmer_ramp_tb;

    localparam int NCH          = tpd_pkg::CHANNELS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASES       = 6;

    // Directed stimulus row: an item, plus a typed-in result where one is given.
    typedef struct {
        tpd_pkg::in_t  item;
        bit            use_lit;
        tpd_pkg::out_t lit;
    } dir_row_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    tpd_pkg::in_t  in_data      = '0;
    logic          out_ready    = 1'b0;
    logic          cfg_write_en = 1'b0;
    logic [1:0]    cfg_index    = '0;
    logic [31:0]   cfg_data     = '0;
    logic          in_ready;
    logic          out_valid;
    tpd_pkg::out_t out_data;

    // Shadow of the configuration registers and the channel state.
    tpd_pkg::cfg_t shadow_cfg;
    logic          latch_set  [NCH];
    logic [6:0]    level_pct  [NCH];
    logic [6:0]    target_pct [NCH];
    logic          gate_on    [NCH];

    tpd_pkg::out_t expected_results[$];
    tpd_pkg::in_t  planned_items[$];
    dir_row_t      dir_rows[$];

    int          mismatches   = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          config_loads = 0;
    int          cycle_count  = 0;
    int          burst_left   = 0;
    bit          tx_bursty    = 1'b1;
    bit          rx_stalls    = 1'b1;
    bit          hold_req     = 1'b0;

    triac_phase_dimmer_ramp uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Compare count for a level, saturated to 16 bits.
    function automatic logic [15:0] phase_compare(input logic [6:0] lvl);
        logic [63:0] diff;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quot;
        diff = (lvl < tpd_pkg::FULL_PERCENT) ? 64'(tpd_pkg::FULL_PERCENT - lvl) : 64'd0;
        num  = diff * 64'(shadow_cfg.core_clock_hz);
        den  = (64'(shadow_cfg.timer_prescaler) + 64'd1) * 64'(tpd_pkg::COMPARE_SCALE);
        quot = num / den;
        return (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
    endfunction

    // Advances the channel state by one item and returns its result.
    function automatic tpd_pkg::out_t dimmer_step(input tpd_pkg::in_t item);
        tpd_pkg::out_t res;
        logic any_pending;
        int   ch;
        int   i;
        res = '0;
        ch  = int'(item.channel);
        case (tpd_pkg::cmd_t'(item.cmd))
            tpd_pkg::CMD_ZERO_CROSS:
            begin
                any_pending = 1'b0;
                for (i = 0; i < NCH; i++)
                    if (latch_set[i])
                        any_pending = 1'b1;
                if (!any_pending)
                begin
                    for (i = 0; i < NCH; i++)
                    begin
                        latch_set[i] = 1'b1;
                        if (level_pct[i] < shadow_cfg.max_percent)
                            gate_on[i] = 1'b0;
                    end
                    res.restart_counter = 1'b1;
                end
            end
            tpd_pkg::CMD_COMPARE:
            begin
                if (ch < NCH)
                begin
                    if (latch_set[ch])
                    begin
                        latch_set[ch] = 1'b0;
                        if (level_pct[ch] > shadow_cfg.min_percent)
                            gate_on[ch] = 1'b1;
                    end
                    if (level_pct[ch] != target_pct[ch])
                    begin
                        if (level_pct[ch] > target_pct[ch])
                            level_pct[ch] = level_pct[ch] - 7'd1;
                        else
                            level_pct[ch] = level_pct[ch] + 7'd1;
                        res.compare_valid   = 1'b1;
                        res.compare_channel = item.channel;
                        res.compare_value   = phase_compare(level_pct[ch]);
                    end
                end
            end
            tpd_pkg::CMD_SET_TARGET:
            begin
                if (ch < NCH)
                    target_pct[ch] = (item.target_level > tpd_pkg::FULL_PERCENT) ?
                                     tpd_pkg::FULL_PERCENT : item.target_level;
            end
            default:
            begin
            end
        endcase
        res.gate_zero = gate_on[0];
        res.gate_one  = gate_on[1];
        res.gate_two  = gate_on[2];
        return res;
    endfunction

    // Target values mostly in range, sometimes above 100 to hit saturation.
    function automatic logic [6:0] random_target();
        if ($urandom_range(0, 6) == 0)
            return 7'($urandom_range(101, 127));
        return 7'($urandom_range(0, 100));
    endfunction

    function automatic tpd_pkg::in_t make_item(input tpd_pkg::cmd_t cmd, input int ch,
                                               input logic [6:0] tgt);
        tpd_pkg::in_t it;
        it.cmd          = cmd;
        it.channel      = 2'(ch);
        it.target_level = tgt;
        return it;
    endfunction

    // Plans one mains half-cycle: targets, a zero cross and the channel
    // compares, sometimes with a compare left out; otherwise raw noise.
    task automatic plan_half_cycle();
        int order[3];
        int k;
        int j;
        int t;
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 4))
                planned_items.push_back(tpd_pkg::in_t'(11'($urandom)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                planned_items.push_back(make_item(tpd_pkg::CMD_SET_TARGET,
                                                  $urandom_range(0, NCH - 1),
                                                  random_target()));
            planned_items.push_back(make_item(tpd_pkg::CMD_ZERO_CROSS,
                                              $urandom_range(0, 3),
                                              7'($urandom_range(0, 127))));
            for (k = 0; k < 3; k++)
                order[k] = k;
            for (k = 2; k > 0; k--)
            begin
                j = $urandom_range(0, k);
                t = order[k];
                order[k] = order[j];
                order[j] = t;
            end
            for (k = 0; k < 3; k++)
                if ($urandom_range(0, 9) != 0)
                    planned_items.push_back(make_item(tpd_pkg::CMD_COMPARE, order[k],
                                                      7'($urandom_range(0, 127))));
            repeat ($urandom_range(0, 3))
                planned_items.push_back(make_item(tpd_pkg::CMD_COMPARE,
                                                  $urandom_range(0, NCH - 1),
                                                  7'($urandom_range(0, 127))));
        end
    endtask

    // Offers one item and waits for it to be accepted; gaps follow bursts.
    task automatic send_item(input tpd_pkg::in_t item, input bit use_lit,
                             input tpd_pkg::out_t lit);
        tpd_pkg::out_t predicted;
        int            gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = dimmer_step(item);
        expected_results.push_back(use_lit ? lit : predicted);
        items_sent++;
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 10);
                in_valid  <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Writes all four registers, one per clock, while the block is idle.
    task automatic load_config(input logic [31:0] hz, input logic [15:0] presc,
                               input logic [6:0] maxp, input logic [6:0] minp);
        cfg_write_en <= 1'b1;
        cfg_index    <= tpd_pkg::REG_CORE_CLOCK;
        cfg_data     <= hz;
        @(posedge clk);
        cfg_index    <= tpd_pkg::REG_PRESCALER;
        cfg_data     <= {16'd0, presc};
        @(posedge clk);
        cfg_index    <= tpd_pkg::REG_MAX_PCT;
        cfg_data     <= {25'd0, maxp};
        @(posedge clk);
        cfg_index    <= tpd_pkg::REG_MIN_PCT;
        cfg_data     <= {25'd0, minp};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        shadow_cfg.core_clock_hz   = hz;
        shadow_cfg.timer_prescaler = presc;
        shadow_cfg.max_percent     = maxp;
        shadow_cfg.min_percent     = minp;
        config_loads++;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Receiver: checks each accepted result and drives its own stall pattern.
    initial
    begin : receiver
        tpd_pkg::out_t exp_r;
        int            stall_left;
        int            run_left;
        int            hold_left;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, actual %h", $time, out_data);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("gate_zero", exp_r.gate_zero, out_data.gate_zero);
                    check_field("gate_one", exp_r.gate_one, out_data.gate_one);
                    check_field("gate_two", exp_r.gate_two, out_data.gate_two);
                    check_field("restart_counter", exp_r.restart_counter,
                                out_data.restart_counter);
                    check_field("compare_valid", exp_r.compare_valid, out_data.compare_valid);
                    check_field("compare_channel", exp_r.compare_channel,
                                out_data.compare_channel);
                    check_field("compare_value", exp_r.compare_value, out_data.compare_value);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (!rx_stalls)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(0, 6);
                run_left   = $urandom_range(1, 8);
                out_ready <= (stall_left == 0);
            end
        end
    end

    // Run limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("triac_phase_dimmer_ramp verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases per setting.
    initial
    begin : stimulus
        int i;
        int p;
        int n;
        shadow_cfg.core_clock_hz   = 32'd48000000;
        shadow_cfg.timer_prescaler = 16'd47;
        shadow_cfg.max_percent     = tpd_pkg::FULL_PERCENT;
        shadow_cfg.min_percent     = 7'd0;
        for (i = 0; i < NCH; i++)
        begin
            latch_set[i]  = 1'b0;
            level_pct[i]  = 7'd0;
            target_pct[i] = 7'd0;
            gate_on[i]    = 1'b0;
        end

        // Directed rows run with the reset settings; the typed-in results
        // hold 1 percent step counts of (100 - level) * 100.
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 0, 7'd0), 1'b1, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_NOP, 3, 7'd127), 1'b1, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_SET_TARGET, 0, 7'd127), 1'b1, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_SET_TARGET, 3, 7'd50), 1'b1, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 3, 7'd0), 1'b1, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_ZERO_CROSS, 0, 7'd0), 1'b1,
                             '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 16'd0}});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_ZERO_CROSS, 2, 7'd0), 1'b1, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 0, 7'd0), 1'b1,
                             '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 2'd0, 16'd9900}});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 0, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_SET_TARGET, 1, 7'd100), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_SET_TARGET, 2, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 1, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 2, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_ZERO_CROSS, 1, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 0, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 1, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 2, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_SET_TARGET, 2, 7'd101), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 2, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_ZERO_CROSS, 3, 7'd127), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_SET_TARGET, 0, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 0, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 1, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_COMPARE, 2, 7'd0), 1'b0, '0});
        dir_rows.push_back('{make_item(tpd_pkg::CMD_NOP, 0, 7'd0), 1'b0, '0});

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].use_lit, dir_rows[i].lit);
        drain_results();

        // Random phases, one register setting each.
        for (p = 0; p < PHASES; p++)
        begin
            tx_bursty = 1'b1;
            rx_stalls = 1'b1;
            case (p)
                0:
                begin
                    // Reset values written back; long output hold-off with a
                    // steady sender so the block backs up.
                    load_config(32'd48000000, 16'd47, 7'd100, 7'd0);
                    tx_bursty = 1'b0;
                    hold_req  = 1'b1;
                end
                1: load_config(32'hFFFFFFFF, 16'd0, 7'd50, 7'd10);
                2: load_config(32'd0, 16'hFFFF, 7'd0, 7'd100);
                3:
                begin
                    // Top of the 7-bit register range, no idling on either side.
                    load_config(32'd1, 16'hFFFF, 7'd127, 7'd127);
                    tx_bursty = 1'b0;
                    rx_stalls = 1'b0;
                end
                4: load_config($urandom, 16'($urandom_range(0, 65535)),
                               7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
                default: load_config($urandom_range(1000000, 200000000),
                                     16'($urandom_range(0, 300)),
                                     7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)));
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (planned_items.size() == 0)
                    plan_half_cycle();
                send_item(planned_items.pop_front(), 1'b0, '0);
            end
            planned_items.delete();
            drain_results();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("Covered %0d items over %0d register settings, %0d results checked.",
                 items_sent, config_loads + 1, results_seen);
        $display("Included zero-cross lockout, ramps both ways, saturation and stalls.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("triac_phase_dimmer_ramp verification clean");
        else
            $display("triac_phase_dimmer_ramp verification failed");
        $finish;
    end

endmodule
